// ===== rtl/core/lidar_point_frame_parser_macros.svh =====
// Assertion macros shared by the lidar point frame parser RTL
`ifndef LIDAR_POINT_FRAME_PARSER_MACROS_SVH
`define LIDAR_POINT_FRAME_PARSER_MACROS_SVH

`ifndef SYNTH

// condition a implies condition b in the same cycle
`define LPFP_ASSERT_IMP(lbl, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("lpfp implication check failed");

// condition holds in every cycle out of reset
`define LPFP_ASSERT_ALWAYS(lbl, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (c)) \
        else $error("lpfp invariant check failed");

`else

`define LPFP_ASSERT_IMP(lbl, a, b)

`define LPFP_ASSERT_ALWAYS(lbl, c)

`endif

`endif

// ===== rtl/core/lpfp_pkg.sv =====
// Shared types and constants for the lidar point frame parser
`timescale 1ns / 1ps

package lpfp_pkg;

    // frame geometry
    localparam int POINTS_PER_FRAME_DEF = 12;
    localparam int POINT_BYTES          = 15;
    localparam int POINT_W              = 8 * POINT_BYTES;
    localparam int ASM_W                = POINT_W - 8;
    localparam int NUM_W                = 4;
    localparam int TIME_W               = 32;

    // last byte index inside one point, last header byte, last time byte
    localparam logic [3:0] LAST_POINT_BYTE = 4'(POINT_BYTES - 1);
    localparam logic [3:0] LAST_HDR_BYTE   = 4'd3;
    localparam logic [3:0] LAST_TIME_BYTE  = 4'd3;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_HEADER  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ADDRESS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COMMAND = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET  = 2'd3;

    // configuration reset values
    localparam logic [7:0] HEADER_RST  = 8'd170;
    localparam logic [7:0] ADDRESS_RST = 8'd0;
    localparam logic [7:0] COMMAND_RST = 8'd2;
    localparam logic [7:0] OFFSET_RST  = 8'd0;

    // parser phases
    typedef enum logic [3:0] {
        ST_HDR,
        ST_ADDR,
        ST_CMD,
        ST_OFS0,
        ST_OFS1,
        ST_LEN0,
        ST_LEN1,
        ST_DATA,
        ST_TIME,
        ST_CHECK
    } parse_state_t;

    // one checked frame waiting to be played out
    typedef struct packed {
        logic              bank;
        logic [TIME_W-1:0] frame_time;
    } frame_desc_t;

endpackage

// ===== rtl/core/lpfp_frame_fifo.sv =====
// Two-entry queue of good frames between parser front and point back end
`timescale 1ns / 1ps

module lpfp_frame_fifo (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  lpfp_pkg::frame_desc_t push_desc,
    input  logic                 pop,
    output lpfp_pkg::frame_desc_t head_desc,
    output logic                 empty,
    output logic                 full
);
    import lpfp_pkg::*;

    frame_desc_t ent_reg [2];
    logic        wr_ptr_reg;
    logic        wr_ptr_next;
    logic        rd_ptr_reg;
    logic        rd_ptr_next;
    logic [1:0]  count_reg;
    logic [1:0]  count_next;

    // pointer and occupancy update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ent_reg[wr_ptr_reg] <= push_desc;
        end
    end

    assign head_desc = ent_reg[rd_ptr_reg];
    assign empty     = (count_reg == 2'd0);
    assign full      = (count_reg == 2'd2);

endmodule

// ===== rtl/core/lpfp_front.sv =====
// Parser front: byte hunt, header checks, point assembly and checksum
`timescale 1ns / 1ps

module lpfp_front #(
    parameter int POINTS_PER_FRAME = lpfp_pkg::POINTS_PER_FRAME_DEF,
    parameter int IDX_W            = 4
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // configuration
    input  logic                               cfg_write,
    input  logic [lpfp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [7:0]                         cfg_data,
    // byte input
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [7:0]                         rx_byte,
    // point store write port
    output logic                               wr_en,
    output logic [IDX_W:0]                     wr_addr,
    output logic [lpfp_pkg::POINT_W-1:0]       wr_data,
    // good frame queue
    input  logic                               queue_full,
    output logic                               push,
    output lpfp_pkg::frame_desc_t              push_desc
);
    import lpfp_pkg::*;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(POINTS_PER_FRAME - 1);

    logic [7:0]         header_reg;
    logic [7:0]         address_reg;
    logic [7:0]         command_reg;
    logic [7:0]         offset_reg;

    parse_state_t       state_reg;
    parse_state_t       state_next;
    logic [3:0]         cnt_reg;
    logic [3:0]         cnt_next;
    logic [IDX_W-1:0]   pcnt_reg;
    logic [IDX_W-1:0]   pcnt_next;
    logic [7:0]         sum_reg;
    logic [7:0]         sum_next;
    logic [ASM_W-1:0]   asm_reg;
    logic [ASM_W-1:0]   asm_next;
    logic [TIME_W-1:0]  time_reg;
    logic [TIME_W-1:0]  time_next;
    logic               bank_reg;
    logic               bank_next;
    logic               accept;
    logic               field_ok;

    // a transfer is held off only while both store banks wait for playout
    assign in_stall = queue_full;
    assign accept   = in_valid && !queue_full;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_reg  <= HEADER_RST;
            address_reg <= ADDRESS_RST;
            command_reg <= COMMAND_RST;
            offset_reg  <= OFFSET_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_HEADER:  header_reg  <= cfg_data;
                REG_ADDRESS: address_reg <= cfg_data;
                REG_COMMAND: command_reg <= cfg_data;
                REG_OFFSET:  offset_reg  <= cfg_data;
                default:     ;
            endcase
        end
    end

    // match of the current byte against the field expected in this phase
    always_comb
    begin
        case (state_reg)
            ST_ADDR:           field_ok = (rx_byte == address_reg);
            ST_CMD:            field_ok = (rx_byte == command_reg);
            ST_OFS0, ST_OFS1:  field_ok = (rx_byte == offset_reg);
            default:           field_ok = 1'b1;
        endcase
    end

    // next phase and byte counter
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        if (accept)
        begin
            case (state_reg)
                ST_HDR:
                begin
                    if (rx_byte != header_reg)
                    begin
                        cnt_next = 4'd0;
                    end
                    else if (cnt_reg == LAST_HDR_BYTE)
                    begin
                        cnt_next   = 4'd0;
                        state_next = ST_ADDR;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 4'd1;
                    end
                end
                ST_ADDR: state_next = field_ok ? ST_CMD  : ST_HDR;
                ST_CMD:  state_next = field_ok ? ST_OFS0 : ST_HDR;
                ST_OFS0: state_next = field_ok ? ST_OFS1 : ST_HDR;
                ST_OFS1: state_next = field_ok ? ST_LEN0 : ST_HDR;
                ST_LEN0: state_next = ST_LEN1;
                ST_LEN1: state_next = ST_DATA;
                ST_DATA:
                begin
                    if (cnt_reg == LAST_POINT_BYTE)
                    begin
                        cnt_next = 4'd0;
                        if (pcnt_reg == LAST_IDX)
                        begin
                            state_next = ST_TIME;
                        end
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 4'd1;
                    end
                end
                ST_TIME:
                begin
                    if (cnt_reg == LAST_TIME_BYTE)
                    begin
                        cnt_next   = 4'd0;
                        state_next = ST_CHECK;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 4'd1;
                    end
                end
                ST_CHECK: state_next = ST_HDR;
                default:
                begin
                    state_next = ST_HDR;
                    cnt_next   = 4'd0;
                end
            endcase
        end
    end

    // datapath: checksum, point assembly, store writes, frame commit
    always_comb
    begin
        sum_next  = sum_reg;
        pcnt_next = pcnt_reg;
        asm_next  = asm_reg;
        time_next = time_reg;
        bank_next = bank_reg;
        wr_en     = 1'b0;
        push      = 1'b0;
        if (accept)
        begin
            case (state_reg)
                ST_ADDR, ST_CMD, ST_OFS0, ST_OFS1, ST_LEN0, ST_LEN1:
                begin
                    sum_next = field_ok ? (sum_reg + rx_byte) : 8'd0;
                end
                ST_DATA:
                begin
                    sum_next = sum_reg + rx_byte;
                    if (cnt_reg == LAST_POINT_BYTE)
                    begin
                        wr_en     = 1'b1;
                        pcnt_next = (pcnt_reg == LAST_IDX) ? '0 : IDX_W'(pcnt_reg + 1'b1);
                    end
                    else
                    begin
                        asm_next[8 * cnt_reg +: 8] = rx_byte;
                    end
                end
                ST_TIME:
                begin
                    sum_next = sum_reg + rx_byte;
                    if (cnt_reg == 4'd0)
                    begin
                        time_next = {24'd0, rx_byte};
                    end
                    else
                    begin
                        time_next[8 * cnt_reg[1:0] +: 8] = rx_byte;
                    end
                end
                ST_CHECK:
                begin
                    sum_next  = 8'd0;
                    pcnt_next = '0;
                    if (rx_byte == sum_reg)
                    begin
                        push      = 1'b1;
                        bank_next = !bank_reg;
                    end
                end
                default: ;
            endcase
        end
    end

    assign wr_addr             = {bank_reg, pcnt_reg};
    assign wr_data             = {rx_byte, asm_reg};
    assign push_desc.bank       = bank_reg;
    assign push_desc.frame_time = time_reg;

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_HDR;
            cnt_reg   <= 4'd0;
            pcnt_reg  <= '0;
            sum_reg   <= 8'd0;
            bank_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            pcnt_reg  <= pcnt_next;
            sum_reg   <= sum_next;
            bank_reg  <= bank_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        asm_reg  <= asm_next;
        time_reg <= time_next;
    end

endmodule

// ===== rtl/core/lpfp_back.sv =====
// Point back end: two-bank point store and point playout to the output
`timescale 1ns / 1ps

`include "lidar_point_frame_parser_macros.svh"

module lpfp_back #(
    parameter int POINTS_PER_FRAME = lpfp_pkg::POINTS_PER_FRAME_DEF,
    parameter int IDX_W            = 4
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // store write port from the front
    input  logic                               wr_en,
    input  logic [IDX_W:0]                     wr_addr,
    input  logic [lpfp_pkg::POINT_W-1:0]       wr_data,
    // frame queue head
    input  lpfp_pkg::frame_desc_t              head_desc,
    input  logic                               queue_empty,
    output logic                               pop,
    // point output
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [lpfp_pkg::NUM_W-1:0]         point_number,
    output logic [15:0]                        range_value,
    output logic [15:0]                        noise_level,
    output logic [31:0]                        peak_level,
    output logic [7:0]                         confidence_level,
    output logic [31:0]                        integration_count,
    output logic signed [15:0]                 reference_flight,
    output logic [31:0]                        frame_time,
    output logic                               last_point
);
    import lpfp_pkg::*;

    localparam int               DEPTH    = 2 << IDX_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(POINTS_PER_FRAME - 1);

    logic [POINT_W-1:0] mem [DEPTH];
    logic [POINT_W-1:0] rd_data_reg;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [IDX_W-1:0]   idx_reg;
    logic [IDX_W-1:0]   idx_next;
    logic [NUM_W-1:0]   num_reg;
    logic [TIME_W-1:0]  time_reg;
    logic               last_reg;
    logic               rd_en;

    // a read goes out when a frame waits and the output slot frees up
    assign rd_en = !queue_empty && (!out_valid_reg || !out_stall);
    assign pop   = rd_en && (idx_reg == LAST_IDX);

    always_comb
    begin
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        if (rd_en)
        begin
            out_valid_next = 1'b1;
            idx_next       = (idx_reg == LAST_IDX) ? '0 : IDX_W'(idx_reg + 1'b1);
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            idx_reg       <= idx_next;
        end
    end

    // point store write
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read doubles as the output payload register
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[{head_desc.bank, idx_reg}];
            num_reg     <= NUM_W'(idx_reg);
            time_reg    <= head_desc.frame_time;
            last_reg    <= (idx_reg == LAST_IDX);
        end
    end

    // little-endian field split of one stored point
    assign out_valid         = out_valid_reg;
    assign point_number      = num_reg;
    assign range_value       = rd_data_reg[15:0];
    assign noise_level       = rd_data_reg[31:16];
    assign peak_level        = rd_data_reg[63:32];
    assign confidence_level  = rd_data_reg[71:64];
    assign integration_count = rd_data_reg[103:72];
    assign reference_flight  = $signed(rd_data_reg[119:104]);
    assign frame_time        = time_reg;
    assign last_point        = last_reg;

    // front never writes the bank being played out
    `LPFP_ASSERT_IMP(a_bank_disjoint, wr_en && !queue_empty, wr_addr[IDX_W] != head_desc.bank)
    // playout index stays inside the frame
    `LPFP_ASSERT_ALWAYS(a_idx_range, idx_reg <= LAST_IDX)
    // last mark sits exactly on the final point number
    `LPFP_ASSERT_IMP(a_last_mark, out_valid_reg, last_reg == (num_reg == NUM_W'(LAST_IDX)))

endmodule

// ===== rtl/core/lidar_point_frame_parser.sv =====
// Top level of the lidar point frame parser
`timescale 1ns / 1ps

// Channel  Direction  Handshake            Payload
// input    in         in_valid/in_stall    rx_byte
// output   out        out_valid/out_stall  point_number .. last_point (one point)
// config   in         cfg_write            cfg_index, cfg_data
//
// One byte is taken per cycle while in_stall is low; a good checksum byte queues the
// frame and the back end plays out POINTS_PER_FRAME points, one per cycle while
// out_stall is low, from the store. The point store has two banks, so a new frame is
// parsed while the last one drains; in_stall rises only when both banks hold unplayed
// frames. With the output idle, a frame is registered in the queue before the first
// point is read out. Reset is asynchronous, active low; no clearing pass follows it.

module lidar_point_frame_parser #(
    parameter int POINTS_PER_FRAME = lpfp_pkg::POINTS_PER_FRAME_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [lpfp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]                     cfg_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [7:0]                     rx_byte,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [lpfp_pkg::NUM_W-1:0]     point_number,
    output logic [15:0]                    range_value,
    output logic [15:0]                    noise_level,
    output logic [31:0]                    peak_level,
    output logic [7:0]                     confidence_level,
    output logic [31:0]                    integration_count,
    output logic signed [15:0]             reference_flight,
    output logic [31:0]                    frame_time,
    output logic                           last_point
);
    import lpfp_pkg::*;

    localparam int IDX_W = (POINTS_PER_FRAME > 1) ? $clog2(POINTS_PER_FRAME) : 1;

    logic               wr_en;
    logic [IDX_W:0]     wr_addr;
    logic [POINT_W-1:0] wr_data;
    logic               push;
    frame_desc_t        push_desc;
    logic               pop;
    frame_desc_t        head_desc;
    logic               queue_empty;
    logic               queue_full;

    // byte parser
    lpfp_front #(
        .POINTS_PER_FRAME (POINTS_PER_FRAME),
        .IDX_W            (IDX_W)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .rx_byte    (rx_byte),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data),
        .queue_full (queue_full),
        .push       (push),
        .push_desc  (push_desc)
    );

    // checked frames waiting for playout
    lpfp_frame_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_desc (push_desc),
        .pop       (pop),
        .head_desc (head_desc),
        .empty     (queue_empty),
        .full      (queue_full)
    );

    // point store and playout
    lpfp_back #(
        .POINTS_PER_FRAME (POINTS_PER_FRAME),
        .IDX_W            (IDX_W)
    ) u_back (
        .clk               (clk),
        .rst_n             (rst_n),
        .wr_en             (wr_en),
        .wr_addr           (wr_addr),
        .wr_data           (wr_data),
        .head_desc         (head_desc),
        .queue_empty       (queue_empty),
        .pop               (pop),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .point_number      (point_number),
        .range_value       (range_value),
        .noise_level       (noise_level),
        .peak_level        (peak_level),
        .confidence_level  (confidence_level),
        .integration_count (integration_count),
        .reference_flight  (reference_flight),
        .frame_time        (frame_time),
        .last_point        (last_point)
    );

endmodule
